// ===== src/kth_ancestor_jump_table_macros.svh =====
// ----------------------------------------------------------------------------
// kth_ancestor_jump_table assertion macros
// Shared concurrent assertion forms for the k-th ancestor engine
// ----------------------------------------------------------------------------
`ifndef KTH_ANCESTOR_JUMP_TABLE_MACROS_SVH
`define KTH_ANCESTOR_JUMP_TABLE_MACROS_SVH

// same-cycle implication
`define KAJT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication
`define KAJT_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== src/kajt_pkg.sv =====
// ----------------------------------------------------------------------------
// kajt_pkg
// Transaction types and operation codes of the k-th ancestor engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kajt_pkg;

   localparam int OP_W    = 2;
   localparam int NODE_W  = 10;
   localparam int VALUE_W = 10;
   localparam int COUNT_W = 11;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [NODE_W-1:0]  node;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic              is_answer;
      logic [NODE_W-1:0] ancestor;
      logic              found;
   } rsp_type;

endpackage

// ===== src/kth_ancestor_jump_table.sv =====
// ----------------------------------------------------------------------------
// kth_ancestor_jump_table
// Binary lifting k-th ancestor engine over a jump table memory
// ----------------------------------------------------------------------------
//  channel | ports                           | handshake
//  req     | req_valid req_stall req_data    | accept on valid and not stall
//  rsp     | rsp_valid rsp_stall rsp_data    | accept on valid and not stall
//  csr     | csr_we csr_wdata                | write on csr_we, no wait
//
//  query: one dependent jump table read per level; a query before a build, of a
//  node out of range or with k out of range answers a miss without a walk.
//  build: table passes for levels 1 to LEVELS - 1 over every node, then a depth
//  pass per node, all reads serialized on the one read port
//  reset is synchronous and needs no memory clearing pass
//  requests stall outside idle; a stalled response holds the next result in done
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "kth_ancestor_jump_table_macros.svh"

module kth_ancestor_jump_table #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  kajt_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output kajt_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [kajt_pkg::COUNT_W-1:0]      csr_wdata
);

   localparam int NW        = $clog2(MAX_NODES);
   localparam int EW        = (NW > kajt_pkg::VALUE_W) ? NW : kajt_pkg::VALUE_W;
   localparam int CW        = ($clog2(MAX_NODES + 1) > kajt_pkg::COUNT_W) ?
                              $clog2(MAX_NODES + 1) : kajt_pkg::COUNT_W;
   localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int DW        = LEVELS + 1;
   localparam int KCW       = (DW > kajt_pkg::VALUE_W) ? DW : kajt_pkg::VALUE_W + 1;
   localparam int TBL_DEPTH = MAX_NODES * LEVELS;
   localparam int AW        = $clog2(TBL_DEPTH);
   localparam int RST_CNT   = (MAX_NODES < 1024) ? MAX_NODES : 1024;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_B_RD1   = 4'd1;
   localparam logic [3:0] S_B_RD2   = 4'd2;
   localparam logic [3:0] S_B_WR    = 4'd3;
   localparam logic [3:0] S_D_START = 4'd4;
   localparam logic [3:0] S_D_WALK  = 4'd5;
   localparam logic [3:0] S_D_FINAL = 4'd6;
   localparam logic [3:0] S_Q_WALK  = 4'd7;
   localparam logic [3:0] S_DONE    = 4'd8;

   localparam kajt_pkg::rsp_type ACK_RSP  = '{is_answer: 1'b0, ancestor: '0, found: 1'b0};
   localparam kajt_pkg::rsp_type MISS_RSP = '{is_answer: 1'b1, ancestor: '0, found: 1'b0};

   logic [3:0]              state_ff, state_in;
   logic                    ready_ff, ready_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [NW-1:0]           v_ff, v_in;
   logic [LW-1:0]           j_ff, j_in;
   logic [NW-1:0]           cur_ff, cur_in;
   logic [DW-1:0]           d_ff, d_in;
   logic [LEVELS-1:0]       k_ff, k_in;
   logic                    dep_ok_ff, dep_ok_in;
   kajt_pkg::rsp_type       pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   kajt_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic [EW-1:0]           tbl_mem [TBL_DEPTH];
   logic [EW-1:0]           tbl_rd_ff;
   logic [DW-1:0]           dep_mem [MAX_NODES];
   logic [DW-1:0]           dep_rd_ff;

   logic [LW-1:0]           tbl_rd_lvl;
   logic [NW-1:0]           tbl_rd_node;
   logic [AW-1:0]           tbl_rd_addr;
   logic                    tbl_wr_en;
   logic [LW-1:0]           tbl_wr_lvl;
   logic [NW-1:0]           tbl_wr_node;
   logic [AW-1:0]           tbl_wr_addr;
   logic [EW-1:0]           tbl_wr_data;
   logic                    dep_rd_en;
   logic                    dep_wr_en;
   logic [DW-1:0]           dep_wr_data;

   logic                    req_accept;
   logic                    rsp_free;
   logic [NW-1:0]           hop_src;
   logic                    hop_l0;
   logic [NW-1:0]           hop_out;
   logic                    v_last;
   logic                    k_fits;
   logic                    q_ok;
   logic                    dep_ok_now;
   logic                    ok_now;
   logic [NW-1:0]           step_node;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign tbl_rd_addr = AW'(tbl_rd_lvl) * AW'(MAX_NODES) + AW'(tbl_rd_node);
   assign tbl_wr_addr = AW'(tbl_wr_lvl) * AW'(MAX_NODES) + AW'(tbl_wr_node);

   assign v_last     = (CW'(v_ff) == cnt_ff - CW'(1));
   assign k_fits     = (KCW'(req_data.value) < (KCW'(1) << LEVELS));
   assign q_ok       = ready_ff && (CW'(req_data.node) < cnt_ff) && k_fits;
   assign dep_ok_now = (KCW'(k_ff) <= KCW'(dep_rd_ff));

   // one jump from the registered table read; level 0 folds the root and out-of-range parent rules
   always_comb begin
      hop_src = (state_ff == S_B_RD2) ? v_ff : cur_ff;
      unique case (state_ff) inside
         S_B_RD2, S_B_WR:      hop_l0 = (j_ff == LW'(1));
         S_D_WALK, S_Q_WALK:   hop_l0 = (j_ff == '0);
         S_D_FINAL:            hop_l0 = 1'b1;
         default:              hop_l0 = 1'b0;
      endcase
      if (hop_l0 && ((hop_src == '0) || (CW'(tbl_rd_ff) >= cnt_ff))) begin
         hop_out = '0;
      end else begin
         hop_out = NW'(tbl_rd_ff);
      end
   end

   always_comb begin
      state_in    = state_ff;
      ready_in    = ready_ff;
      cnt_in      = cnt_ff;
      v_in        = v_ff;
      j_in        = j_ff;
      cur_in      = cur_ff;
      d_in        = d_ff;
      k_in        = k_ff;
      dep_ok_in   = dep_ok_ff;
      pend_in     = pend_ff;
      tbl_rd_lvl  = '0;
      tbl_rd_node = cur_ff;
      tbl_wr_en   = 1'b0;
      tbl_wr_lvl  = j_ff;
      tbl_wr_node = v_ff;
      tbl_wr_data = EW'(hop_out);
      dep_rd_en   = 1'b0;
      dep_wr_en   = 1'b0;
      dep_wr_data = '0;
      step_node   = cur_ff;
      ok_now      = dep_ok_ff;

      if (csr_we) begin
         cnt_in   = (CW'(csr_wdata) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(csr_wdata);
         ready_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            tbl_rd_node = NW'(req_data.node);
            if (req_accept) begin
               unique case (req_data.op)
                  kajt_pkg::OP_LOAD: begin
                     ready_in = 1'b0;
                     if ((req_data.node != '0) &&
                         (CW'(req_data.node) < CW'(MAX_NODES))) begin
                        tbl_wr_en   = 1'b1;
                        tbl_wr_lvl  = '0;
                        tbl_wr_node = NW'(req_data.node);
                        tbl_wr_data = EW'(req_data.value);
                     end
                  end
                  kajt_pkg::OP_BUILD: begin
                     v_in = '0;
                     j_in = LW'(1);
                     if (cnt_ff == '0) begin
                        ready_in = 1'b1;
                        pend_in  = ACK_RSP;
                        state_in = S_DONE;
                     end else if (LEVELS == 1) begin
                        state_in = S_D_START;
                     end else begin
                        state_in = S_B_RD1;
                     end
                  end
                  kajt_pkg::OP_QUERY: begin
                     if (q_ok) begin
                        cur_in    = NW'(req_data.node);
                        k_in      = LEVELS'(req_data.value);
                        j_in      = '0;
                        dep_rd_en = 1'b1;
                        state_in  = S_Q_WALK;
                     end else begin
                        pend_in  = MISS_RSP;
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_B_RD1: begin
            tbl_rd_lvl  = j_ff - LW'(1);
            tbl_rd_node = v_ff;
            state_in    = S_B_RD2;
         end
         S_B_RD2: begin
            // second hop starts from the first hop's landing node
            cur_in      = hop_out;
            tbl_rd_lvl  = j_ff - LW'(1);
            tbl_rd_node = hop_out;
            state_in    = S_B_WR;
         end
         S_B_WR: begin
            tbl_wr_en = 1'b1;
            if (v_last) begin
               v_in = '0;
               if (j_ff == LW'(LEVELS - 1)) begin
                  state_in = S_D_START;
               end else begin
                  j_in     = j_ff + LW'(1);
                  state_in = S_B_RD1;
               end
            end else begin
               v_in     = v_ff + NW'(1);
               state_in = S_B_RD1;
            end
         end
         S_D_START: begin
            if (v_ff == '0) begin
               dep_wr_en = 1'b1;
               if (v_last) begin
                  ready_in = 1'b1;
                  pend_in  = ACK_RSP;
                  state_in = S_DONE;
               end else begin
                  v_in = v_ff + NW'(1);
               end
            end else begin
               cur_in      = v_ff;
               d_in        = '0;
               j_in        = LW'(LEVELS - 1);
               tbl_rd_lvl  = LW'(LEVELS - 1);
               tbl_rd_node = v_ff;
               state_in    = S_D_WALK;
            end
         end
         S_D_WALK: begin
            // descend from the top level, taking every jump that stays below the root
            if (hop_out != '0) begin
               step_node = hop_out;
               d_in      = d_ff | (DW'(1) << j_ff);
            end
            cur_in      = step_node;
            tbl_rd_node = step_node;
            if (j_ff == '0) begin
               tbl_rd_lvl = '0;
               state_in   = S_D_FINAL;
            end else begin
               tbl_rd_lvl = j_ff - LW'(1);
               j_in       = j_ff - LW'(1);
            end
         end
         S_D_FINAL: begin
            // a chain that never reaches the root gets depth zero
            dep_wr_en   = 1'b1;
            dep_wr_data = (hop_out == '0) ? d_ff + DW'(1) : '0;
            if (v_last) begin
               ready_in = 1'b1;
               pend_in  = ACK_RSP;
               state_in = S_DONE;
            end else begin
               v_in     = v_ff + NW'(1);
               state_in = S_D_START;
            end
         end
         S_Q_WALK: begin
            if (k_ff[j_ff]) begin
               step_node = hop_out;
            end
            cur_in = step_node;
            if (j_ff == '0) begin
               dep_ok_in = dep_ok_now;
               ok_now    = dep_ok_now;
            end
            if (j_ff == LW'(LEVELS - 1)) begin
               pend_in.is_answer = 1'b1;
               pend_in.ancestor  = ok_now ? kajt_pkg::NODE_W'(step_node) : '0;
               pend_in.found     = ok_now;
               state_in          = S_DONE;
            end else begin
               j_in        = j_ff + LW'(1);
               tbl_rd_lvl  = j_ff + LW'(1);
               tbl_rd_node = step_node;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == S_DONE) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b0;
         cnt_ff       <= CW'(RST_CNT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      j_ff        <= j_in;
      cur_ff      <= cur_in;
      d_ff        <= d_in;
      k_ff        <= k_in;
      dep_ok_ff   <= dep_ok_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // jump table: level-major layout, one read and one write port
   always_ff @(posedge clock) begin
      if (tbl_wr_en) begin
         tbl_mem[tbl_wr_addr] <= tbl_wr_data;
      end
      tbl_rd_ff <= tbl_mem[tbl_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (dep_wr_en) begin
         dep_mem[v_ff] <= dep_wr_data;
      end
      if (dep_rd_en) begin
         dep_rd_ff <= dep_mem[NW'(req_data.node)];
      end
   end

   `KAJT_ASSERT_IMP(a_build_level, clock, reset, state_ff == S_B_WR, j_ff != '0)
   `KAJT_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
                    $past(state_ff) == S_DONE)
   `KAJT_ASSERT_NXT(a_query_steps, clock, reset, state_ff == S_Q_WALK,
                    (state_ff == S_DONE) ||
                    ((state_ff == S_Q_WALK) && (j_ff == $past(j_ff) + LW'(1))))
   `KAJT_ASSERT_NXT(a_done_holds, clock, reset,
                    (state_ff == S_DONE) && rsp_valid_ff && rsp_stall,
                    (state_ff == S_DONE) && rsp_valid_ff)

endmodule
